/* rtl/core/kncd_pkg.sv */
`default_nettype none
package kncd_pkg;

   localparam int unsigned MAX_RANK_DEF    = 16;
   localparam int unsigned COUNT_LIMIT_DEF = 65535;

   localparam int unsigned DIST_W  = 32;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned RANK_W  = 5;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned CSR_IDX_W = 1;

   // Register indexes of the write port
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POINTS = 1'd1;

   localparam logic [DIST_W-1:0]  EMPTY_SLOT      = '1;
   localparam logic [RANK_W-1:0]  MIN_POINTS_RST  = 5'd6;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              last_of_point;
   } req_type;

   typedef struct packed {
      logic               core_valid;
      logic [DIST_W-1:0]  kth_distance;
      logic [COUNT_W-1:0] neighbor_count;
   } rsp_type;

   // Per-cycle control shared by every cell of the chain
   typedef struct packed {
      logic insert;
      logic flush;
   } cell_ctl_type;

endpackage
`default_nettype wire

/* rtl/core/kth_nearest_core_distance.sv */
`default_nettype none
// Channel  | direction | ports                              | word
// req      | in        | req_valid, req_ready, req_data     | one distance, last flag
// rsp      | out       | rsp_valid, rsp_ready, rsp_data     | core result of one point
// csr      | in        | csr_we, csr_index, csr_data        | radius, min_points
//
// One distance word per cycle: every cell of the sorted chain compares and
// shifts in the same cycle, so the insert never stalls the stream.
// Reset (synchronous) empties every slot to all ones, clears the count, loads
// radius 0 and min_points 6.
// The result of a flagged word sits in the rsp register from the next cycle; the
// req side stalls only while that register holds a word rsp does not take.
module kth_nearest_core_distance #(
   parameter int unsigned MAX_RANK    = kncd_pkg::MAX_RANK_DEF,
   parameter int unsigned COUNT_LIMIT = kncd_pkg::COUNT_LIMIT_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire kncd_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output kncd_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [kncd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [kncd_pkg::CSR_W-1:0]     csr_data
);

   localparam int unsigned CAP_INT = (COUNT_LIMIT > 65535) ? 65535 : COUNT_LIMIT;
   localparam logic [kncd_pkg::COUNT_W-1:0] CAP = kncd_pkg::COUNT_W'(CAP_INT);
   localparam int unsigned RK_W = 7;
   localparam logic [RK_W-1:0] MAX_RANK_RK = RK_W'(MAX_RANK);

   // Configuration registers
   logic [kncd_pkg::DIST_W-1:0] radius_ff;
   logic [kncd_pkg::RANK_W-1:0] min_points_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= '0;
         min_points_ff <= kncd_pkg::MIN_POINTS_RST;
      end else if (csr_we) begin
         case (csr_index)
            kncd_pkg::CSR_RADIUS:     radius_ff     <= csr_data;
            kncd_pkg::CSR_MIN_POINTS: min_points_ff <= csr_data[kncd_pkg::RANK_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the rsp register frees itself when rsp takes its word
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    req_fire;
   logic    is_last;
   logic    in_radius;

   assign req_ready = rsp_ready || !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign is_last   = req_fire && req_data.last_of_point;
   assign in_radius = req_fire && (req_data.distance <= radius_ff);

   kncd_pkg::cell_ctl_type ctl;
   assign ctl.insert = in_radius;
   assign ctl.flush  = is_last;

   // Effective rank: min_points clamped to 1..MAX_RANK
   logic [RK_W-1:0] mp_rk;
   logic [RK_W-1:0] rank_rk;

   always_comb begin
      mp_rk   = (min_points_ff == '0) ? RK_W'(1) : RK_W'(min_points_ff);
      rank_rk = (mp_rk > MAX_RANK_RK) ? MAX_RANK_RK : mp_rk;
   end

   // Sorted chain of slots, ascending from cell 0
   logic [kncd_pkg::DIST_W-1:0] slot      [MAX_RANK];
   logic [kncd_pkg::DIST_W-1:0] slot_next [MAX_RANK];
   logic [kncd_pkg::DIST_W-1:0] left_slot [MAX_RANK];

   for (genvar g = 0; g < MAX_RANK; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_slot[g] = '0;
      end else begin : g_body
         assign left_slot[g] = slot[g-1];
      end
      kncd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .distance  (req_data.distance),
         .left_slot (left_slot[g]),
         .slot      (slot[g]),
         .slot_next (slot_next[g])
      );
   end

   // Pick the rank-th slot after this word's insert: one-hot AND-OR over cells
   logic [kncd_pkg::DIST_W-1:0] rank_slot;

   always_comb begin
      rank_slot = '0;
      for (int i = 0; i < MAX_RANK; i++) begin
         if (rank_rk == RK_W'(i + 1)) begin
            rank_slot = rank_slot | slot_next[i];
         end
      end
   end

   // Saturating neighbour count
   logic [kncd_pkg::COUNT_W-1:0] count_ff;
   logic [kncd_pkg::COUNT_W-1:0] count_next;
   logic [kncd_pkg::COUNT_W-1:0] count_in;

   always_comb begin
      count_next = count_ff;
      if (in_radius && (count_ff < CAP)) begin
         count_next = count_ff + kncd_pkg::COUNT_W'(1);
      end
      count_in = is_last ? '0 : count_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result register
   kncd_pkg::rsp_type rsp_data_ff;
   kncd_pkg::rsp_type rsp_data_in;
   logic              core;

   always_comb begin
      core                       = count_next >= kncd_pkg::COUNT_W'(rank_rk);
      rsp_data_in.core_valid     = core;
      rsp_data_in.kth_distance   = core ? rank_slot : '0;
      rsp_data_in.neighbor_count = count_next;
      rsp_valid_in               = is_last || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the payload only with a fresh result; hold it while stalled
   always_ff @(posedge clock) begin
      if (is_last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      is_last |=> rsp_valid)
      else $error("flagged word did not produce a result");

   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP)
      else $error("neighbour count beyond its cap");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      is_last |=> (count_ff == '0) && (slot[0] == kncd_pkg::EMPTY_SLOT))
      else $error("point state not cleared after flagged word");

   a_zero_when_not_core: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.core_valid) |-> (rsp_data.kth_distance == '0))
      else $error("core distance set for a non-core point");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (MAX_RANK > 1) |-> (slot[0] <= slot[MAX_RANK-1]))
      else $error("slot chain out of order");
`endif

endmodule
`default_nettype wire

/* rtl/core/kncd_cell.sv */
`default_nettype none
module kncd_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire kncd_pkg::cell_ctl_type      ctl,
   input  wire logic [kncd_pkg::DIST_W-1:0] distance,
   input  wire logic [kncd_pkg::DIST_W-1:0] left_slot,
   output logic      [kncd_pkg::DIST_W-1:0] slot,
   output logic      [kncd_pkg::DIST_W-1:0] slot_next
);

   logic [kncd_pkg::DIST_W-1:0] slot_ff;
   logic [kncd_pkg::DIST_W-1:0] slot_in;

   // Take the neighbour's value when the new distance lands left of us,
   // take the distance itself when it lands here, else hold; a flush empties the slot.
   always_comb begin
      slot_next = slot_ff;
      if (ctl.insert && (slot_ff > distance)) begin
         slot_next = (left_slot > distance) ? left_slot : distance;
      end
      slot_in = ctl.flush ? kncd_pkg::EMPTY_SLOT : slot_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= kncd_pkg::EMPTY_SLOT;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule
`default_nettype wire

/* tb/tb_kth_nearest_core_distance.sv */
module tb_kth_nearest_core_distance;

   localparam int unsigned RANK_SLOTS = kncd_pkg::MAX_RANK_DEF;
   localparam int unsigned COUNT_CAP  =
      (kncd_pkg::COUNT_LIMIT_DEF > 65535) ? 65535 : kncd_pkg::COUNT_LIMIT_DEF;

   localparam int RANDOM_WORDS  = 820;    // random distance words after the directed part
   localparam int QUIET_TAIL    = 250;    // final stretch with no idling on either side
   localparam int LONG_HOLD     = 64;     // receiver hold-off that backs the block up
   localparam int SETTLE_CYCLES = 6;      // idle time after the expected results have drained
   localparam int STALL_LIMIT   = 4000;   // cycles without any handshake before giving up

   // Running copy of the core-distance unit: keeps its own registers, the
   // sorted smallest-neighbour slots and the count, and queues the core
   // result of every flagged word until the block hands it over.
   class core_result_board;
      logic [kncd_pkg::DIST_W-1:0]  radius;
      logic [kncd_pkg::RANK_W-1:0]  min_points;
      logic [kncd_pkg::DIST_W-1:0]  kept [RANK_SLOTS];
      logic [kncd_pkg::COUNT_W-1:0] near_count;
      kncd_pkg::rsp_type            pending [$];
      int unsigned                  mismatches;

      function new();
         radius     = '0;
         min_points = kncd_pkg::MIN_POINTS_RST;
         mismatches = 0;
         clear_point();
      endfunction

      function void clear_point();
         foreach (kept[i]) kept[i] = kncd_pkg::EMPTY_SLOT;
         near_count = '0;
      endfunction

      function void load_reg(logic [kncd_pkg::CSR_IDX_W-1:0] idx,
                             logic [kncd_pkg::CSR_W-1:0] value);
         if (idx == kncd_pkg::CSR_RADIUS) radius = value[kncd_pkg::DIST_W-1:0];
         else if (idx == kncd_pkg::CSR_MIN_POINTS) min_points = value[kncd_pkg::RANK_W-1:0];
      endfunction

      function void absorb_word(kncd_pkg::req_type w);
         int unsigned       slot;
         int unsigned       rank;
         kncd_pkg::rsp_type r;
         if (w.distance <= radius) begin
            if (near_count < COUNT_CAP) near_count++;
            // shift larger entries up one slot; a distance not below the top slot is lost
            if (w.distance < kept[RANK_SLOTS-1]) begin
               slot = RANK_SLOTS - 1;
               while (slot > 0 && kept[slot-1] > w.distance) begin
                  kept[slot] = kept[slot-1];
                  slot--;
               end
               kept[slot] = w.distance;
            end
         end
         if (!w.last_of_point) return;
         rank = min_points;
         if (rank < 1) rank = 1;
         if (rank > RANK_SLOTS) rank = RANK_SLOTS;
         r.core_valid     = (near_count >= rank);
         r.kth_distance   = r.core_valid ? kept[rank-1] : '0;
         r.neighbor_count = near_count;
         pending = {pending, r};
         clear_point();
      endfunction

      function void check_result(kncd_pkg::rsp_type got);
         kncd_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: core result with nothing expected, got valid %0b kth %h count %0d",
                     $time, got.core_valid, got.kth_distance, got.neighbor_count);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (got.core_valid !== want.core_valid) begin
            $display("%0t: core_valid expected %0b, got %0b",
                     $time, want.core_valid, got.core_valid);
            mismatches++;
         end
         if (got.kth_distance !== want.kth_distance) begin
            $display("%0t: kth_distance expected %h, got %h",
                     $time, want.kth_distance, got.kth_distance);
            mismatches++;
         end
         if (got.neighbor_count !== want.neighbor_count) begin
            $display("%0t: neighbor_count expected %0d, got %0d",
                     $time, want.neighbor_count, got.neighbor_count);
            mismatches++;
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   kncd_pkg::req_type              req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   kncd_pkg::rsp_type              rsp_data;
   logic                           csr_we;
   logic [kncd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [kncd_pkg::CSR_W-1:0]     csr_data;

   core_result_board board = new();

   bit                          sender_gaps_on;
   bit                          rsp_stalls_on;
   bit                          long_hold_due;
   bit                          point_open;
   int                          words_sent;
   logic [kncd_pkg::DIST_W-1:0] last_distance;

   kth_nearest_core_distance u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Offer one distance word from a falling edge and hold it until taken.
   // A random gap may come first; the word is noted at the accepting edge.
   task automatic send_word(input logic [kncd_pkg::DIST_W-1:0] value, input logic last);
      kncd_pkg::req_type w;
      w.distance      = value;
      w.last_of_point = last;
      if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = w;
      do @(posedge clock); while (!req_ready);
      board.absorb_word(w);
      words_sent++;
      point_open    = !last;
      last_distance = value;
      @(negedge clock);
   endtask

   // Pick distances around the radius so the compare sees both sides of it,
   // with ties, zero and the all-ones value that matches an empty slot.
   function automatic logic [kncd_pkg::DIST_W-1:0] pick_distance();
      logic [kncd_pkg::DIST_W-1:0] r;
      logic [kncd_pkg::DIST_W-1:0] d;
      r = board.radius;
      case ($urandom_range(0, 9))
         0:       d = '0;
         1:       d = '1;
         2:       d = r;
         3:       d = r + 1'b1;
         4:       d = last_distance;
         5, 6, 7: d = $urandom_range(r, 0);
         default: d = $urandom();
      endcase
      return d;
   endfunction

   function automatic logic [kncd_pkg::CSR_W-1:0] pick_radius();
      logic [kncd_pkg::CSR_W-1:0] r;
      case ($urandom_range(0, 5))
         0:       r = '0;
         1:       r = '1;
         2:       r = $urandom();
         default: r = {16'($urandom_range(0, 64)), 16'($urandom())};
      endcase
      return r;
   endfunction

   // Out-of-range ranks (0 and above the slot count) get their share too.
   function automatic logic [kncd_pkg::CSR_W-1:0] pick_min_points();
      logic [kncd_pkg::CSR_W-1:0] m;
      case ($urandom_range(0, 7))
         0:       m = 0;
         1:       m = 1;
         2:       m = RANK_SLOTS;
         3:       m = $urandom_range(RANK_SLOTS + 1, 31);
         default: m = $urandom_range(1, RANK_SLOTS);
      endcase
      return m;
   endfunction

   // Mostly short points, some longer than the slot count, some flag-only.
   function automatic int pick_length();
      int n;
      case ($urandom_range(0, 9))
         0:       n = 0;
         1, 2:    n = $urandom_range(16, 40);
         default: n = $urandom_range(1, 15);
      endcase
      return n;
   endfunction

   task automatic send_point(input int extra);
      repeat (extra) send_word(pick_distance(), 1'b0);
      send_word(pick_distance(), 1'b1);
   endtask

   // Drop valid, drain every expected result, then let the pipeline empty.
   task automatic settle_block();
      req_valid = 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [kncd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [kncd_pkg::CSR_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_data  = value;
      board.load_reg(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Receiver: ready changes on the falling edge. Random stalls while
   // enabled; a requested long hold-off overrides them.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready = 1'b0;
         end else if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left     = LONG_HOLD - 1;
            rsp_ready     = 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 8) - 1;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Check every core result at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   // Give up when neither side has moved a word for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("kth_nearest_core_distance regression: fail");
      $finish;
   end

   initial begin : stimulus
      int  base;
      bit  quiet_tail;
      bit  pressure_done;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_index      = kncd_pkg::CSR_RADIUS;
      csr_data       = '0;
      sender_gaps_on = 1'b0;
      rsp_stalls_on  = 1'b0;
      long_hold_due  = 1'b0;
      point_open     = 1'b0;
      words_sent     = 0;
      last_distance  = '0;
      pressure_done  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset registers: radius 0, so only a zero distance is a neighbour.
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'h0000_0000, 1'b1);
      // flag with nothing before it still yields a result
      send_word(32'h0000_0005, 1'b1);

      // Widest radius and a rank of zero, which behaves as rank one;
      // an all-ones distance must count although it looks like an empty slot.
      settle_block();
      write_reg(kncd_pkg::CSR_RADIUS, '1);
      write_reg(kncd_pkg::CSR_MIN_POINTS, 0);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h1234_5678, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hEDCB_A987, 1'b1);

      // Rank above the slot count clamps to the last slot: fill all of them.
      settle_block();
      write_reg(kncd_pkg::CSR_MIN_POINTS, 31);
      for (int i = 0; i < 15; i++) send_word(32'h8000_0000 - i * 32'h0111_0000, 1'b0);
      send_word(32'h0000_0001, 1'b1);

      // Change both registers part-way through a point: the rank in force on
      // the flag decides, and words already counted stay counted.
      settle_block();
      write_reg(kncd_pkg::CSR_MIN_POINTS, 2);
      send_word(32'h0000_0003, 1'b0);
      send_word(32'h0000_0009, 1'b0);
      settle_block();
      write_reg(kncd_pkg::CSR_MIN_POINTS, 1);
      write_reg(kncd_pkg::CSR_RADIUS, 32'h0000_0008);
      send_word(32'h0000_0007, 1'b1);

      // Random phases: new settings between phases, a few points each, and
      // now and then a phase that stops inside a point so the next settings
      // land mid-point.
      base = words_sent;
      while (words_sent - base < RANDOM_WORDS) begin
         quiet_tail = (words_sent - base + QUIET_TAIL >= RANDOM_WORDS);
         settle_block();
         if ($urandom_range(0, 3) != 0) write_reg(kncd_pkg::CSR_RADIUS, pick_radius());
         if ($urandom_range(0, 3) != 0)
            write_reg(kncd_pkg::CSR_MIN_POINTS, pick_min_points());
         sender_gaps_on = !quiet_tail && ($urandom_range(0, 3) != 0);
         rsp_stalls_on  = !quiet_tail && ($urandom_range(0, 3) != 0);
         if (!pressure_done && words_sent - base >= 200) begin
            // hold the receiver off and keep flagging, so the result register
            // fills and the block has to stall its input
            long_hold_due  = 1'b1;
            sender_gaps_on = 1'b0;
            repeat (24) send_word(pick_distance(), 1'b1);
            pressure_done = 1'b1;
         end
         repeat ($urandom_range(1, 5)) send_point(pick_length());
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 10)) send_word(pick_distance(), 1'b0);
      end
      if (point_open) send_word(pick_distance(), 1'b1);
      req_valid = 1'b0;

      // Drain, then allow for anything stray before the verdict.
      while (board.pending.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0)
         $display("kth_nearest_core_distance regression: pass");
      else
         $display("kth_nearest_core_distance regression: fail");
      $finish;
   end

endmodule
